>>> rtl/nrmc_pkg.sv
// Shared constants, types and helper functions for the RMC position parser.
`default_nettype none

package nrmc_pkg;

  localparam int MAX_LINE_DEF    = 127;
  localparam int FRAC_DIGITS_DEF = 5;

  localparam int BYTE_W  = 8;
  localparam int COORD_W = 35;
  localparam int MAG_W   = 34;
  localparam int X_W     = 24;   // rem * 40 + scaled fraction, below 2^24
  localparam int Q_W     = 19;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam int         PREFIX_LEN  = 6;
  localparam logic [2:0] PREFIX_DONE = 3'd6;
  localparam logic [2:0] PREFIX_BAD  = 3'd7;
  localparam logic [2:0] POS_TALKER  = 3'd2;

  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_MIN    = 4'd6;
  localparam logic [3:0] FLD_SAT    = 4'd15;

  localparam logic [2:0] CNT_SAT   = 3'd7;
  localparam logic [2:0] CNT_SHORT = 3'd4;

  // Whole part kept as degrees and minutes; 99999 saturates to 999 / 99.
  localparam logic [9:0] DEG_MAX = 10'd999;
  localparam logic [6:0] REM_MAX = 7'd99;

  localparam longint unsigned E7           = 64'd10000000;
  localparam longint unsigned MIN_E7_DIV60 = 64'd166666;  // 1e7 = 60 * 166666 + 40
  localparam longint unsigned MIN_E7_REM60 = 64'd40;
  localparam longint unsigned RECIP60      = 64'd17895698; // ceil(2^30 / 60)
  localparam int              RECIP_SH     = 30;

  typedef enum logic [1:0] {
    PH_WHOLE,
    PH_FRAC,
    PH_STOP
  } phase_e;

  function automatic int unsigned pow10(input int n);
    int unsigned p;
    p = 1;
    for (int k = 0; k < n; k++) p = p * 10;
    return p;
  endfunction

  function automatic logic prefix_char_ok(input logic [2:0] pos, input logic [7:0] c);
    logic ok;
    case (pos)
      3'd0:    ok = (c == CH_DOLLAR);
      3'd1:    ok = (c == CH_G);
      3'd2:    ok = (c == CH_P) || (c == CH_N);
      3'd3:    ok = (c == CH_R);
      3'd4:    ok = (c == CH_M);
      default: ok = (c == CH_C);
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> rtl/nmea_rmc_position_parser_core.sv
// RMC sentence parser: per-byte field scanner and pipelined coordinate conversion.
//
//   channel | signals                                        | role
//   --------+------------------------------------------------+---------------------
//   in      | in_valid_i, in_stall_o, rx_byte_i               | one NMEA character
//   out     | out_valid_o, out_stall_i, latitude_e7_o,        | position of a valid
//           | longitude_e7_o, combined_talker_o              | RMC sentence
//
// One character is taken every cycle unless the input is stalled; the field scanner
// state is registered. A newline ending a matching sentence enters the conversion
// pipeline (constant scaling, reciprocal multiply for /60, sum and sign), and its
// result is registered at the output. Reset clears the line state and all valid
// bits. The input stalls only while every conversion stage and the output register
// hold items and the output is stalled.
`default_nettype none

module nmea_rmc_position_parser_core #(
  parameter int MAX_LINE    = nrmc_pkg::MAX_LINE_DEF,
  parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [nrmc_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [nrmc_pkg::COORD_W-1:0] latitude_e7_o,
  output logic signed [nrmc_pkg::COORD_W-1:0] longitude_e7_o,
  output logic                                combined_talker_o
);
  import nrmc_pkg::*;

  localparam int LEN_W   = $clog2(MAX_LINE + 1);
  localparam int FRAC_W  = $clog2(10 ** FRAC_DIGITS);
  localparam int TAKEN_W = $clog2(FRAC_DIGITS + 1);
  localparam int PROD_W  = 2 * X_W + 1;

  // line state
  logic [LEN_W-1:0]   len_q, len_d;
  logic [3:0]         fld_q, fld_d;
  logic [2:0]         prefix_q, prefix_d;
  logic               talker_q, talker_d;
  logic               status_q, status_d;
  logic               fstart_q, fstart_d;
  logic [9:0]         deg_q[2], deg_d[2];
  logic [6:0]         rem_q[2], rem_d[2];
  logic [FRAC_W-1:0]  fsc_q[2], fsc_d[2];
  phase_e             phase_q[2], phase_d[2];
  logic [TAKEN_W-1:0] taken_q[2], taken_d[2];
  logic [2:0]         cnt_q[2], cnt_d[2];
  logic               neg_q[2], neg_d[2];

  // conversion pipeline
  logic              v1_q, v2_q, v3_q, out_v_q;
  logic              rdy1, rdy2, rdy3;
  logic              accept, push;
  logic [9:0]        s1_deg[2];
  logic [6:0]        s1_rem[2];
  logic [FRAC_W-1:0] s1_fsc[2];
  logic              s1_zero[2], s1_neg[2], s1_talk;
  logic [X_W-1:0]    s2_x[2];
  logic [MAG_W-1:0]  s2_a[2];
  logic              s2_zero[2], s2_neg[2], s2_talk;
  logic [Q_W-1:0]    s3_q[2];
  logic [MAG_W-1:0]  s3_a[2];
  logic              s3_zero[2], s3_neg[2], s3_talk;
  logic [COORD_W-1:0] res_d[2], res_q[2];
  logic              talk_q;

  assign rdy3       = !out_v_q || !out_stall_i;
  assign rdy2       = !v3_q || rdy3;
  assign rdy1       = !v2_q || rdy2;
  assign in_stall_o = v1_q && !rdy1;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- scanner
  always_comb begin
    logic       is_dig;
    logic [3:0] dig;
    logic [9:0] t;
    logic [15:0] hp;
    logic [3:0] hi;
    logic [9:0] lo;
    logic [13:0] dn;
    logic [FRAC_W-1:0] wgt;
    logic [3:0] cfld;

    len_d    = len_q;
    fld_d    = fld_q;
    prefix_d = prefix_q;
    talker_d = talker_q;
    status_d = status_q;
    fstart_d = fstart_q;
    for (int i = 0; i < 2; i++) begin
      deg_d[i]   = deg_q[i];
      rem_d[i]   = rem_q[i];
      fsc_d[i]   = fsc_q[i];
      phase_d[i] = phase_q[i];
      taken_d[i] = taken_q[i];
      cnt_d[i]   = cnt_q[i];
      neg_d[i]   = neg_q[i];
    end
    push   = 1'b0;
    is_dig = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);
    dig    = 4'(rx_byte_i - CH_ZERO);
    t      = '0;
    hp     = '0;
    hi     = '0;
    lo     = '0;
    dn     = '0;
    wgt    = '0;
    cfld   = '0;

    if (accept) begin
      if (rx_byte_i == CH_LF) begin
        push     = (prefix_q == PREFIX_DONE) && (fld_q >= FLD_MIN) && status_q;
        len_d    = '0;
        fld_d    = '0;
        prefix_d = '0;
        talker_d = 1'b0;
        status_d = 1'b0;
        fstart_d = 1'b0;
        for (int i = 0; i < 2; i++) begin
          deg_d[i]   = '0;
          rem_d[i]   = '0;
          fsc_d[i]   = '0;
          phase_d[i] = PH_WHOLE;
          taken_d[i] = '0;
          cnt_d[i]   = '0;
          neg_d[i]   = 1'b0;
        end
      end else if (rx_byte_i != CH_CR && len_q < LEN_W'(MAX_LINE)) begin
        if (len_q < LEN_W'(PREFIX_LEN) && LEN_W'(prefix_q) == len_q) begin
          if (len_q[2:0] == POS_TALKER) talker_d = (rx_byte_i == CH_N);
          prefix_d = prefix_char_ok(len_q[2:0], rx_byte_i) ? prefix_q + 3'd1 : PREFIX_BAD;
        end
        len_d = len_q + LEN_W'(1);

        if (rx_byte_i == CH_COMMA) begin
          if (fld_q != FLD_SAT) fld_d = fld_q + 4'd1;
          fstart_d = 1'b1;
        end else begin
          if (fstart_q) begin
            if (fld_q == FLD_STATUS) status_d = (rx_byte_i == CH_A);
            if (fld_q == FLD_NS)     neg_d[0] = (rx_byte_i == CH_S);
            if (fld_q == FLD_EW)     neg_d[1] = (rx_byte_i == CH_W);
          end
          fstart_d = 1'b0;

          for (int i = 0; i < 2; i++) begin
            cfld = (i == 0) ? FLD_LAT : FLD_LON;
            // whole digit: whole*10+d split again into degrees and minutes
            t  = 10'(rem_q[i]) * 10'd10 + 10'(dig);
            hp = 16'(t) * 16'd41;
            hi = hp[15:12];
            lo = t - 10'(hi) * 10'd100;
            dn = 14'(deg_q[i]) * 14'd10 + 14'(hi);
            wgt = '0;
            for (int k = 0; k < FRAC_DIGITS; k++) begin
              if (taken_q[i] == TAKEN_W'(k)) wgt = FRAC_W'(pow10(FRAC_DIGITS - 1 - k));
            end
            if (fld_q == cfld) begin
              if (cnt_q[i] < CNT_SAT) cnt_d[i] = cnt_q[i] + 3'd1;
              case (phase_q[i])
                PH_WHOLE: begin
                  if (is_dig) begin
                    if (dn > 14'(DEG_MAX)) begin
                      deg_d[i] = DEG_MAX;
                      rem_d[i] = REM_MAX;
                    end else begin
                      deg_d[i] = dn[9:0];
                      rem_d[i] = lo[6:0];
                    end
                  end else begin
                    phase_d[i] = (rx_byte_i == CH_DOT) ? PH_FRAC : PH_STOP;
                  end
                end
                PH_FRAC: begin
                  if (is_dig) begin
                    if (taken_q[i] < TAKEN_W'(FRAC_DIGITS)) begin
                      // fraction kept already scaled to FRAC_DIGITS places
                      fsc_d[i]   = fsc_q[i] + FRAC_W'(dig) * wgt;
                      taken_d[i] = taken_q[i] + TAKEN_W'(1);
                    end
                  end else begin
                    phase_d[i] = PH_STOP;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      fld_q    <= '0;
      prefix_q <= '0;
      talker_q <= 1'b0;
      status_q <= 1'b0;
      fstart_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        deg_q[i]   <= '0;
        rem_q[i]   <= '0;
        fsc_q[i]   <= '0;
        phase_q[i] <= PH_WHOLE;
        taken_q[i] <= '0;
        cnt_q[i]   <= '0;
        neg_q[i]   <= 1'b0;
      end
    end else begin
      len_q    <= len_d;
      fld_q    <= fld_d;
      prefix_q <= prefix_d;
      talker_q <= talker_d;
      status_q <= status_d;
      fstart_q <= fstart_d;
      for (int i = 0; i < 2; i++) begin
        deg_q[i]   <= deg_d[i];
        rem_q[i]   <= rem_d[i];
        fsc_q[i]   <= fsc_d[i];
        phase_q[i] <= phase_d[i];
        taken_q[i] <= taken_d[i];
        cnt_q[i]   <= cnt_d[i];
        neg_q[i]   <= neg_d[i];
      end
    end
  end

  // ------------------------------------------------------- pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (push)      v1_q <= 1'b1;
      else if (rdy1) v1_q <= 1'b0;
      if (rdy1) v2_q    <= v1_q;
      if (rdy2) v3_q    <= v2_q;
      if (rdy3) out_v_q <= v3_q;
    end
  end

  // -------------------------------------------------------- pipeline data
  always_comb begin
    logic [MAG_W-1:0] mag;
    for (int i = 0; i < 2; i++) begin
      mag = s3_a[i] + MAG_W'(s3_q[i]);
      if (s3_zero[i])     res_d[i] = '0;
      else if (s3_neg[i]) res_d[i] = -COORD_W'(mag);
      else                res_d[i] = COORD_W'(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [PROD_W-1:0] prod;
    if (push) begin
      for (int i = 0; i < 2; i++) begin
        s1_deg[i]  <= deg_q[i];
        s1_rem[i]  <= rem_q[i];
        s1_fsc[i]  <= fsc_q[i];
        s1_zero[i] <= (cnt_q[i] < CNT_SHORT);
        s1_neg[i]  <= neg_q[i];
      end
      s1_talk <= talker_q;
    end
    if (rdy1) begin
      // minutes * 1e7 / 60 = rem * 166666 + (rem * 40 + frac * 10^(7-F)) / 60
      for (int i = 0; i < 2; i++) begin
        s2_x[i]    <= X_W'(s1_rem[i]) * X_W'(MIN_E7_REM60)
                    + X_W'(s1_fsc[i]) * X_W'(pow10(7 - FRAC_DIGITS));
        s2_a[i]    <= MAG_W'(s1_deg[i]) * MAG_W'(E7)
                    + MAG_W'(s1_rem[i]) * MAG_W'(MIN_E7_DIV60);
        s2_zero[i] <= s1_zero[i];
        s2_neg[i]  <= s1_neg[i];
      end
      s2_talk <= s1_talk;
    end
    if (rdy2) begin
      for (int i = 0; i < 2; i++) begin
        prod       = PROD_W'(s2_x[i]) * PROD_W'(RECIP60);
        s3_q[i]    <= prod[RECIP_SH +: Q_W];
        s3_a[i]    <= s2_a[i];
        s3_zero[i] <= s2_zero[i];
        s3_neg[i]  <= s2_neg[i];
      end
      s3_talk <= s2_talk;
    end
    if (rdy3) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      talk_q   <= s3_talk;
    end
  end

  assign out_valid_o       = out_v_q;
  assign latitude_e7_o     = res_q[0];
  assign longitude_e7_o    = res_q[1];
  assign combined_talker_o = talk_q;

endmodule

`default_nettype wire
